[hdl/stg_pkg.sv]
// shared types, constants and command codes for the square tone queue generator
`timescale 1ns / 1ps

package stg_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam int STEP_W   = 32;
    localparam int LENGTH_W = 24;
    localparam int FREQ_W   = 16;
    localparam int AMP_W    = 15;
    localparam int SAMPLE_W = 16;
    localparam int CMD_W    = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = AMP_W;

    // phase step = floor(freq * 2^32 / 48000) = (freq * ceil(2^57 / 48000)) >> 25
    localparam int SAMPLE_RATE = 48000;
    localparam int STEP_MULT_W = 42;
    localparam int STEP_SHIFT  = 25;
    localparam logic [STEP_MULT_W-1:0] STEP_MULT = 42'd3002399751581;

    localparam logic [CMD_W-1:0] CMD_TONE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE = 1'd1;

    localparam logic [AMP_W-1:0] AMPLITUDE_RESET = 15'd8192;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [FREQ_W-1:0]   freq_hz;
        logic [LENGTH_W-1:0] duration_frames;
    } in_item_t;

    typedef struct packed {
        logic                       accepted;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       playing;
    } out_item_t;

    typedef struct packed {
        logic [STEP_W-1:0]   step;
        logic [LENGTH_W-1:0] length;
    } queue_entry_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic flush;
    } queue_ctrl_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

endpackage

[hdl/stg_step.sv]
// frequency to phase step conversion by reciprocal multiplication
`timescale 1ns / 1ps

module stg_step
(
    input  logic [stg_pkg::FREQ_W-1:0] freq_hz,
    output logic [stg_pkg::STEP_W-1:0] step
);

    localparam int PROD_W = stg_pkg::FREQ_W + stg_pkg::STEP_MULT_W;

    logic [PROD_W-1:0] product;

    // exact for every 16-bit frequency, wraps modulo 2^32 above the sample rate
    assign product = PROD_W'(freq_hz) * PROD_W'(stg_pkg::STEP_MULT);
    assign step    = product[stg_pkg::STEP_SHIFT +: stg_pkg::STEP_W];

endmodule

[hdl/stg_queue.sv]
// shifting tone queue: push at the fill level, pop from entry zero
`timescale 1ns / 1ps

module stg_queue
#(
    parameter int DEPTH = stg_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  stg_pkg::queue_ctrl_t  ctrl,
    input  stg_pkg::queue_entry_t push_entry,
    output stg_pkg::queue_entry_t head,
    output stg_pkg::queue_status_t status
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    stg_pkg::queue_entry_t entry_reg [DEPTH];
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.flush)
        begin
            count_next = '0;
        end
        else if (ctrl.push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctrl.pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // entries carry no reset, only those below the count are ever read
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_entry
        if (i < DEPTH - 1)
        begin : g_shift
            always_ff @(posedge clk)
            begin
                if (ctrl.pop)
                begin
                    entry_reg[i] <= entry_reg[i+1];
                end
                else if (ctrl.push && count_reg == CNT_W'(i))
                begin
                    entry_reg[i] <= push_entry;
                end
            end
        end
        else
        begin : g_last
            always_ff @(posedge clk)
            begin
                if (ctrl.push && count_reg == CNT_W'(i))
                begin
                    entry_reg[i] <= push_entry;
                end
            end
        end
    end

    assign head         = entry_reg[0];
    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == CNT_W'(DEPTH));

endmodule

[hdl/square_tone_queue_generator_unit.sv]
// top level: input register, tone playback state and result register
//
//   channel | direction | handshake            | payload
//   in      | in        | in_valid / in_stall  | in_item  (cmd, freq_hz, duration_frames)
//   out     | out       | out_valid / out_stall| out_item (accepted, sample, playing)
//   cfg     | in        | cfg_write            | cfg_index, cfg_data
//
// one item per cycle while out_stall allows; a taken item passes the input register, then the result register
// the step multiplier and the queue update sit between the input and result registers
// reset empties the queue, clears the tone state, enable 1, amplitude 8192
// out_stall holds the result register, a stalled result stops the input register
// only when that register is also full
`timescale 1ns / 1ps

module square_tone_queue_generator_unit
#(
    parameter int QUEUE_DEPTH = stg_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  stg_pkg::in_item_t                 in_item,
    output logic                              out_valid,
    input  logic                              out_stall,
    output stg_pkg::out_item_t                out_item,
    input  logic                              cfg_write,
    input  logic [stg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [stg_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic                           in_valid_reg;
    stg_pkg::in_item_t              in_item_reg;
    logic                           out_valid_reg;
    stg_pkg::out_item_t             out_item_reg;
    stg_pkg::out_item_t             out_item_next;

    logic                           enable_reg;
    logic [stg_pkg::AMP_W-1:0]      amplitude_reg;
    logic [stg_pkg::STEP_W-1:0]     cur_step_reg;
    logic [stg_pkg::STEP_W-1:0]     cur_step_next;
    logic [stg_pkg::LENGTH_W-1:0]   rem_reg;
    logic [stg_pkg::LENGTH_W-1:0]   rem_next;
    logic [stg_pkg::STEP_W-1:0]     phase_reg;
    logic [stg_pkg::STEP_W-1:0]     phase_next;

    logic                           advance;
    logic                           go;
    logic                           cfg_disable;
    logic                           tone_ok;
    logic                           need_pop;
    logic [stg_pkg::STEP_W-1:0]     eff_step;
    logic [stg_pkg::STEP_W-1:0]     eff_phase;
    logic [stg_pkg::LENGTH_W-1:0]   eff_rem;
    logic [stg_pkg::SAMPLE_W-1:0]   amp_ext;

    stg_pkg::queue_ctrl_t           q_ctrl;
    stg_pkg::queue_entry_t          q_push;
    stg_pkg::queue_entry_t          q_head;
    stg_pkg::queue_status_t         q_status;

    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = in_valid_reg && !advance;
    assign go        = in_valid_reg && advance;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    assign cfg_disable = cfg_write && (cfg_index == stg_pkg::REG_ENABLE) && !cfg_data[0];

    stg_step u_step
    (
        .freq_hz (in_item_reg.freq_hz),
        .step    (q_push.step)
    );

    assign q_push.length = in_item_reg.duration_frames;

    stg_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (q_ctrl),
        .push_entry (q_push),
        .head       (q_head),
        .status     (q_status)
    );

    assign tone_ok = enable_reg && (in_item_reg.freq_hz != '0)
                     && (in_item_reg.duration_frames != '0) && !q_status.full;

    // a finished tone hands over to the queue head with the phase cleared
    assign need_pop  = (rem_reg == '0) && !q_status.empty;
    assign eff_step  = need_pop ? q_head.step : cur_step_reg;
    assign eff_phase = need_pop ? '0 : phase_reg;
    assign eff_rem   = need_pop ? q_head.length : rem_reg;
    assign amp_ext   = {1'b0, amplitude_reg};

    always_comb
    begin
        q_ctrl        = '0;
        out_item_next = '0;
        cur_step_next = cur_step_reg;
        rem_next      = rem_reg;
        phase_next    = phase_reg;
        if (cfg_disable)
        begin
            q_ctrl.flush = 1'b1;
            rem_next     = '0;
        end
        else if (go)
        begin
            unique case (in_item_reg.cmd)
                stg_pkg::CMD_TONE:
                begin
                    q_ctrl.push            = tone_ok;
                    out_item_next.accepted = tone_ok;
                end
                stg_pkg::CMD_TICK:
                begin
                    q_ctrl.pop    = need_pop;
                    cur_step_next = eff_step;
                    phase_next    = eff_phase;
                    rem_next      = eff_rem;
                    if (eff_rem != '0)
                    begin
                        out_item_next.playing = 1'b1;
                        out_item_next.sample  = eff_phase[stg_pkg::STEP_W-1]
                                                ? signed'(stg_pkg::SAMPLE_W'(0) - amp_ext)
                                                : signed'(amp_ext);
                        phase_next = eff_phase + eff_step;
                        rem_next   = eff_rem - stg_pkg::LENGTH_W'(1);
                    end
                end
                stg_pkg::CMD_FLUSH:
                begin
                    q_ctrl.flush = 1'b1;
                    rem_next     = '0;
                end
                default:
                begin
                    // unused command leaves everything as it is
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            enable_reg    <= 1'b1;
            amplitude_reg <= stg_pkg::AMPLITUDE_RESET;
            cur_step_reg  <= '0;
            rem_reg       <= '0;
            phase_reg     <= '0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (cfg_write)
            begin
                unique case (cfg_index)
                    stg_pkg::REG_ENABLE:    enable_reg    <= cfg_data[0];
                    stg_pkg::REG_AMPLITUDE: amplitude_reg <= cfg_data;
                    default:                enable_reg    <= enable_reg;
                endcase
            end
            cur_step_reg <= cur_step_next;
            rem_reg      <= rem_next;
            phase_reg    <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_item_reg <= in_item;
        end
        if (go)
        begin
            out_item_reg <= out_item_next;
        end
    end

    a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
        go && (in_item_reg.cmd == stg_pkg::CMD_FLUSH) |=> q_status.empty && (rem_reg == '0))
        else $error("flush left a tone queued or playing");

    a_idle_tick_silent: assert property (@(posedge clk) disable iff (!rst_n)
        go && (in_item_reg.cmd == stg_pkg::CMD_TICK) && (rem_reg == '0) && q_status.empty
        |=> !out_item_reg.playing && (out_item_reg.sample == '0))
        else $error("idle tick produced a sample");

    a_pop_phase_start: assert property (@(posedge clk) disable iff (!rst_n)
        go && q_ctrl.pop && !cfg_disable |=> (phase_reg == cur_step_reg))
        else $error("new tone did not start at phase zero");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_ctrl.push |-> !q_status.full && enable_reg)
        else $error("tone queued while full or disabled");

endmodule

[bench/square_tone_queue_generator_unit_test.sv]
// testbench for the square tone queue generator: directed table, random phases, scoreboard
`timescale 1ns / 1ps

module square_tone_queue_generator_unit_test;

    localparam int TONE_SLOTS   = stg_pkg::QUEUE_DEPTH_DEFAULT;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;

    // the one command code the block has no use for
    localparam logic [stg_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;

    typedef struct {
        stg_pkg::in_item_t  item;
        bit                 typed;
        stg_pkg::out_item_t want;
    } script_row_t;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_stall;
    stg_pkg::in_item_t              in_item;
    logic                           out_valid;
    logic                           out_stall;
    stg_pkg::out_item_t             out_item;
    logic                           cfg_write;
    logic [stg_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [stg_pkg::CFG_DATA_W-1:0] cfg_data;

    // mirror of the tone engine
    logic [stg_pkg::STEP_W-1:0]   slot_step [TONE_SLOTS];
    logic [stg_pkg::LENGTH_W-1:0] slot_len [TONE_SLOTS];
    int                           tones_waiting;
    logic [stg_pkg::STEP_W-1:0]   cur_step;
    logic [stg_pkg::LENGTH_W-1:0] samples_left;
    logic [stg_pkg::STEP_W-1:0]   phase_acc;
    logic                         en_q;
    logic [stg_pkg::AMP_W-1:0]    amp_q;

    stg_pkg::out_item_t owed_results[$];
    script_row_t        script[$];
    int                 mismatches;
    int                 clk_count;
    bit                 gaps_on;

    square_tone_queue_generator_unit #(.QUEUE_DEPTH(TONE_SLOTS)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        clk_count++;
        if (clk_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic note_mismatch(string what, int got, int want);
        mismatches++;
        $display("mismatch at cycle %0d: %s got %0d want %0d", clk_count, what, got, want);
    endtask

    function automatic stg_pkg::out_item_t tone_engine_step(stg_pkg::in_item_t it);
        stg_pkg::out_item_t           res;
        logic [63:0]                  scaled;
        logic [stg_pkg::SAMPLE_W-1:0] mag;
        res = '0;
        case (it.cmd)
            stg_pkg::CMD_TONE:
            begin
                if (en_q && it.freq_hz != 0 && it.duration_frames != 0
                    && tones_waiting < TONE_SLOTS)
                begin
                    scaled = {16'd0, it.freq_hz, 32'd0} / 64'(stg_pkg::SAMPLE_RATE);
                    slot_step[tones_waiting] = scaled[stg_pkg::STEP_W-1:0];
                    slot_len[tones_waiting]  = it.duration_frames;
                    tones_waiting++;
                    res.accepted = 1'b1;
                end
            end
            stg_pkg::CMD_TICK:
            begin
                if (samples_left == 0 && tones_waiting > 0)
                begin
                    cur_step     = slot_step[0];
                    samples_left = slot_len[0];
                    for (int i = 1; i < TONE_SLOTS; i++)
                    begin
                        slot_step[i-1] = slot_step[i];
                        slot_len[i-1]  = slot_len[i];
                    end
                    tones_waiting--;
                    phase_acc = '0;
                end
                if (samples_left != 0)
                begin
                    mag         = {1'b0, amp_q};
                    res.sample  = phase_acc[stg_pkg::STEP_W-1] ? (16'd0 - mag) : mag;
                    res.playing = 1'b1;
                    phase_acc   = phase_acc + cur_step;
                    samples_left = samples_left - 1'b1;
                end
            end
            stg_pkg::CMD_FLUSH:
            begin
                tones_waiting = 0;
                samples_left  = '0;
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic script_row_t make_row(logic [stg_pkg::CMD_W-1:0] c, int f, int d,
                                             bit typed, bit acc, int smp, bit play);
        script_row_t r;
        r.item.cmd             = c;
        r.item.freq_hz         = f[stg_pkg::FREQ_W-1:0];
        r.item.duration_frames = d[stg_pkg::LENGTH_W-1:0];
        r.typed                = typed;
        r.want.accepted        = acc;
        r.want.sample          = smp[stg_pkg::SAMPLE_W-1:0];
        r.want.playing         = play;
        return r;
    endfunction

    function automatic stg_pkg::in_item_t pick_cmd_item();
        stg_pkg::in_item_t it;
        int                roll;
        it.freq_hz         = 16'($urandom());
        it.duration_frames = 24'($urandom());
        roll = $urandom_range(0, 99);
        if (roll < 38)
        begin
            it.cmd = stg_pkg::CMD_TONE;
            roll = $urandom_range(0, 99);
            if (roll < 8)
                it.freq_hz = '0;
            else if (roll < 55)
                it.freq_hz = 16'($urandom_range(1, 65535));
            else
                it.freq_hz = 16'($urandom_range(20, 4000));
            roll = $urandom_range(0, 99);
            if (roll < 8)
                it.duration_frames = '0;
            else if (roll < 78)
                it.duration_frames = 24'($urandom_range(1, 6));
            else if (roll < 93)
                it.duration_frames = 24'($urandom_range(1, 200));
        end
        else if (roll < 90)
            it.cmd = stg_pkg::CMD_TICK;
        else if (roll < 96)
            it.cmd = stg_pkg::CMD_FLUSH;
        else
            it.cmd = CMD_SPARE;
        return it;
    endfunction

    // entered and left at a falling edge
    task automatic drive_item(stg_pkg::in_item_t it, bit typed, stg_pkg::out_item_t want);
        stg_pkg::out_item_t predicted;
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do
            @(posedge clk);
        while (in_stall);
        predicted = tone_engine_step(it);
        owed_results.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [stg_pkg::CFG_IDX_W-1:0] idx,
                             logic [stg_pkg::CFG_DATA_W-1:0] val);
        in_valid <= 1'b0;
        while (owed_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        if (idx == stg_pkg::REG_ENABLE)
        begin
            en_q = val[0];
            // disabling drops the queue and the tone in progress
            if (!val[0])
            begin
                tones_waiting = 0;
                samples_left  = '0;
            end
        end
        else
            amp_q = val;
    endtask

    task automatic run_phase(bit en, logic [stg_pkg::AMP_W-1:0] amp, int count, bit gaps);
        write_reg(stg_pkg::REG_ENABLE, {14'($urandom()), en});
        write_reg(stg_pkg::REG_AMPLITUDE, amp);
        gaps_on = gaps;
        repeat (count) drive_item(pick_cmd_item(), 1'b0, '0);
    endtask

    // receiver side: stall in random bursts
    initial
    begin
        int burst;
        burst = 0;
        forever
        begin
            @(negedge clk);
            if (burst > 0)
            begin
                burst--;
                out_stall <= 1'b1;
            end
            else if (gaps_on && rst_n && $urandom_range(0, 9) == 0)
            begin
                burst = $urandom_range(1, 18) - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        stg_pkg::out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (owed_results.size() == 0)
                note_mismatch("result with nothing expected, sample", int'(out_item.sample), 0);
            else
            begin
                want = owed_results.pop_front();
                if (out_item.accepted !== want.accepted)
                    note_mismatch("accepted", out_item.accepted, want.accepted);
                if (out_item.sample !== want.sample)
                    note_mismatch("sample", int'(out_item.sample), int'(want.sample));
                if (out_item.playing !== want.playing)
                    note_mismatch("playing", out_item.playing, want.playing);
            end
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_item    = '0;
        out_stall  = 1'b0;
        cfg_write  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        mismatches = 0;
        clk_count  = 0;
        gaps_on    = 1'b1;

        tones_waiting = 0;
        cur_step      = '0;
        samples_left  = '0;
        phase_acc     = '0;
        en_q          = 1'b1;
        amp_q         = stg_pkg::AMPLITUDE_RESET;
        for (int i = 0; i < TONE_SLOTS; i++)
        begin
            slot_step[i] = '0;
            slot_len[i]  = '0;
        end

        // idle tick, unused command, rejected requests, fill the queue, then overflow it
        script.push_back(make_row(stg_pkg::CMD_TICK,  0,     0,        1, 0, 0,     0));
        script.push_back(make_row(CMD_SPARE,          65535, 16777215, 1, 0, 0,     0));
        script.push_back(make_row(stg_pkg::CMD_TONE,  0,     5,        1, 0, 0,     0));
        script.push_back(make_row(stg_pkg::CMD_TONE,  1000,  0,        1, 0, 0,     0));
        script.push_back(make_row(stg_pkg::CMD_TONE,  65535, 1,        1, 1, 0,     0));
        script.push_back(make_row(stg_pkg::CMD_TONE,  24000, 3,        1, 1, 0,     0));
        script.push_back(make_row(stg_pkg::CMD_TONE,  1,     16777215, 1, 1, 0,     0));
        script.push_back(make_row(stg_pkg::CMD_TONE,  48000, 2,        1, 1, 0,     0));
        script.push_back(make_row(stg_pkg::CMD_TONE,  440,   7,        1, 0, 0,     0));
        // single-frame 65535 Hz tone, then the half-rate tone flips sign every sample, then a flush
        script.push_back(make_row(stg_pkg::CMD_TICK,  0,     0,        1, 0, 8192,  1));
        script.push_back(make_row(stg_pkg::CMD_TICK,  0,     0,        1, 0, 8192,  1));
        script.push_back(make_row(stg_pkg::CMD_TICK,  0,     0,        1, 0, -8192, 1));
        script.push_back(make_row(stg_pkg::CMD_TICK,  0,     0,        1, 0, 8192,  1));
        script.push_back(make_row(stg_pkg::CMD_TICK,  0,     0,        1, 0, 8192,  1));
        script.push_back(make_row(stg_pkg::CMD_TICK,  0,     0,        0, 0, 0,     0));
        script.push_back(make_row(stg_pkg::CMD_FLUSH, 0,     0,        1, 0, 0,     0));
        script.push_back(make_row(stg_pkg::CMD_TICK,  0,     0,        1, 0, 0,     0));
        // sample-rate tone aliases to a zero step
        script.push_back(make_row(stg_pkg::CMD_TONE,  48000, 2,        1, 1, 0,     0));
        script.push_back(make_row(stg_pkg::CMD_TICK,  0,     0,        1, 0, 8192,  1));
        script.push_back(make_row(stg_pkg::CMD_TICK,  0,     0,        1, 0, 8192,  1));
        script.push_back(make_row(stg_pkg::CMD_TICK,  0,     0,        1, 0, 0,     0));
        script.push_back(make_row(stg_pkg::CMD_TONE,  12345, 4,        0, 0, 0,     0));
        script.push_back(make_row(stg_pkg::CMD_TICK,  0,     0,        0, 0, 0,     0));
        script.push_back(make_row(stg_pkg::CMD_TICK,  0,     0,        0, 0, 0,     0));

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (script[i])
            drive_item(script[i].item, script[i].typed, script[i].want);

        run_phase(1'b1, 15'($urandom()), 200, 1'b1);
        run_phase(1'b1, 15'd32767,       150, 1'b1);
        run_phase(1'b0, 15'd32767,        60, 1'b1);
        run_phase(1'b1, 15'd0,           100, 1'b1);
        run_phase(1'b1, 15'd1,           150, 1'b1);
        run_phase(1'b1, 15'($urandom()), 240, 1'b0);

        in_valid <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
